// ----- rtl/core/tdt_pkg.sv -----
// Package for the tag deduplication table: table sizing, field widths,
// operation and status codes, and the packed layout of one table entry.
// No dependencies.
`default_nettype none

package tdt_pkg;

  // Number of table entries (legal range 1 to 63).
  localparam int TableDepth = 32;

  // Address width of the entry memory and width of counters that must hold the depth itself.
  localparam int TableIdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int TableCntW  = $clog2(TableDepth + 1);

  localparam int TagW       = 32;
  localparam int TempW      = 16;
  localparam int ReadsW     = 16;
  localparam int SeenCountW = 6;

  // Operation codes carried on the input channel.
  localparam logic OpInsert = 1'b0;
  localparam logic OpSweep  = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_UPDATED = 2'd1,
    ST_FULL    = 2'd2,
    ST_SWEEP   = 2'd3
  } status_e;

  // One stored table entry; the seen marks live in flip-flops outside the memory.
  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic signed [TempW-1:0]  temp;
    logic [ReadsW-1:0]        reads;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// ----- rtl/core/tdt_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Read data holds its value in cycles without a read. No dependencies.
`default_nettype none

module tdt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   wr_en_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]                       wr_data_i,
  input  wire logic                                   rd_en_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output      logic [Width-1:0]                       rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tag_dedup_table.sv -----
// Top level of the tag deduplication table: sequencer, seen marks and result register.
// Depends on tdt_pkg and on the generic RAM tdt_ram.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one command per transaction:
//   operation 0 inserts or updates tag_id_i with temperature_i, operation 1 sweeps the
//   table. The output channel (out_valid_o / out_stall_i) carries the results. An insert
//   gives exactly one result; a sweep gives one result per entry marked seen, in table
//   order, followed by a summary transaction with last_o set.
//   The block works on one command at a time and raises in_stall_o until that command
//   has written its final result to the output register. An insert walks the filled
//   entries through the single read port of the entry memory, one entry per cycle,
//   comparing each against the tag. A sweep steps past unseen entries, reads each
//   seen entry before emitting it, and gives the summary last.
//   Results sit in an output register, so a new command may be accepted while the last
//   result still waits; if the receiver keeps out_stall_i high, the sequencer holds at
//   its next result until the register frees up.
//   Reset clears the fill level, the seen marks and the control state. The entry memory
//   is not cleared: only entries below the fill level are ever read.
`default_nettype none

module tag_dedup_table
  import tdt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic                    operation_i,
  input  wire logic [TagW-1:0]         tag_id_i,
  input  wire logic signed [TempW-1:0] temperature_i,

  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [1:0]              status_o,
  output      logic                    entry_present_o,
  output      logic [TagW-1:0]         tag_id_res_o,
  output      logic signed [TempW-1:0] temperature_res_o,
  output      logic [ReadsW-1:0]       read_count_o,
  output      logic [SeenCountW-1:0]   seen_count_o,
  output      logic                    last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SWEEP,
    S_EMIT
  } state_e;

  typedef struct packed {
    status_e                 status;
    logic                    present;
    logic [TagW-1:0]         tag;
    logic signed [TempW-1:0] temp;
    logic [ReadsW-1:0]       reads;
    logic [SeenCountW-1:0]   seen;
    logic                    last;
  } res_t;

  state_e                 state_q, state_d;
  logic [TableCntW-1:0]   fill_q, fill_d;
  logic [TableCntW-1:0]   idx_q, idx_d;
  logic [TableCntW-1:0]   found_q, found_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [TableIdxW-1:0]   chk_idx_q, chk_idx_d;
  logic [TableDepth-1:0]  seen_q, seen_d;
  logic [TagW-1:0]        tag_q, tag_d;
  logic signed [TempW-1:0] temp_q, temp_d;
  logic                   out_valid_q, out_valid_d;
  res_t                   out_q, out_d;

  // Memory port signals.
  logic                   rd_en;
  logic [TableIdxW-1:0]   rd_addr;
  logic                   wr_en;
  logic [TableIdxW-1:0]   wr_addr;
  entry_t                 wr_data;
  entry_t                 rd_data;

  // Helpers for the sequencer.
  logic                   out_free;
  logic                   hit;
  logic                   more;
  logic [TableIdxW-1:0]   idx_lo;
  logic [ReadsW-1:0]      reads_inc;
  logic [TableCntW-1:0]   found_inc;
  logic                   add_done;

  tdt_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_entries (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The result register is free when empty or when its content leaves this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  // The read data belongs to entry chk_idx_q whenever chk_vld_q is set.
  assign hit       = chk_vld_q && (rd_data.tag == tag_q);
  assign more      = (idx_q < fill_q);
  assign idx_lo    = idx_q[TableIdxW-1:0];
  assign reads_inc = (rd_data.reads == '1) ? rd_data.reads : rd_data.reads + ReadsW'(1);
  assign found_inc = found_q + TableCntW'(1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    found_d     = found_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    seen_d      = seen_q;
    tag_d       = tag_q;
    temp_d      = temp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    rd_addr     = idx_lo;
    wr_en       = 1'b0;
    wr_addr     = chk_idx_q;
    wr_data     = '0;
    add_done    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tag_d     = tag_id_i;
          temp_d    = temperature_i;
          idx_d     = '0;
          found_d   = '0;
          chk_vld_d = 1'b0;
          state_d   = (operation_i == OpSweep) ? S_SWEEP : S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (hit) begin
          // Matching entry: refresh the temperature and bump the saturating count.
          if (out_free) begin
            wr_en         = 1'b1;
            wr_addr       = chk_idx_q;
            wr_data.tag   = tag_q;
            wr_data.temp  = temp_q;
            wr_data.reads = reads_inc;
            seen_d[chk_idx_q] = 1'b1;
            out_d         = '{ST_UPDATED, 1'b0, tag_q, temp_q, reads_inc, '0, 1'b1};
            out_valid_d   = 1'b1;
            chk_vld_d     = 1'b0;
            state_d       = S_IDLE;
          end
        end else if (more) begin
          rd_en     = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_lo;
          idx_d     = idx_q + TableCntW'(1);
        end else begin
          // Every filled entry was compared without a match.
          chk_vld_d = 1'b0;
          if (out_free) begin
            if (fill_q == TableCntW'(TableDepth)) begin
              out_d = '{ST_FULL, 1'b0, tag_q, temp_q, '0, '0, 1'b1};
            end else begin
              wr_en         = 1'b1;
              wr_addr       = fill_q[TableIdxW-1:0];
              wr_data.tag   = tag_q;
              wr_data.temp  = temp_q;
              wr_data.reads = ReadsW'(1);
              seen_d[fill_q[TableIdxW-1:0]] = 1'b1;
              fill_d        = fill_q + TableCntW'(1);
              add_done      = 1'b1;
              out_d         = '{ST_ADDED, 1'b0, tag_q, temp_q, ReadsW'(1), '0, 1'b1};
            end
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end

      S_SWEEP: begin
        if (more) begin
          if (seen_q[idx_lo]) begin
            rd_en     = 1'b1;
            chk_idx_d = idx_lo;
            state_d   = S_EMIT;
          end else begin
            idx_d = idx_q + TableCntW'(1);
          end
        end else if (out_free) begin
          out_d       = '{ST_SWEEP, 1'b0, '0, '0, '0, SeenCountW'(found_q), 1'b1};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_d = '{ST_SWEEP, 1'b1, rd_data.tag, rd_data.temp, rd_data.reads,
                    SeenCountW'(found_inc), 1'b0};
          out_valid_d       = 1'b1;
          found_d           = found_inc;
          seen_d[chk_idx_q] = 1'b0;
          idx_d             = idx_q + TableCntW'(1);
          state_d           = S_SWEEP;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      found_q     <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured command and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    temp_q <= temp_d;
    out_q  <= out_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign entry_present_o   = out_q.present;
  assign tag_id_res_o      = out_q.tag;
  assign temperature_res_o = out_q.temp;
  assign read_count_o      = out_q.reads;
  assign seen_count_o      = out_q.seen;
  assign last_o            = out_q.last;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TableCntW'(TableDepth))
    else $error("fill level exceeds table depth");

  a_seen_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q >> fill_q) == '0)
    else $error("seen mark set on an unfilled entry");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= fill_q)
    else $error("sweep found more entries than are filled");

  a_insert_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ST_SWEEP) |-> out_q.last && !out_q.present)
    else $error("insert result not marked as final");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_done |=> fill_q == $past(fill_q) + TableCntW'(1))
    else $error("new entry did not advance the fill level");
`endif

endmodule

`default_nettype wire
